@@ rtl/rtct_pkg.sv @@
// shared constants and types for the ray crash time block
package rtct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int EPS_WIDTH = 16;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 16'd7;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-3:0] REG_EPSILON = '0;

    typedef enum logic [1:0] {
        MODE_REJECT,
        MODE_GENERAL,
        MODE_OWNX,
        MODE_COLLINEAR
    } mode_t;

endpackage

@@ rtl/rtct_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating signed result
module rtct_div #(
    parameter int CW = rtct_pkg::COORD_WIDTH_DEF,
    parameter int NW = 2 * rtct_pkg::COORD_WIDTH_DEF,
    parameter int DW = rtct_pkg::COORD_WIDTH_DEF,
    parameter type SIDE_T = logic
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [NW-1:0]        in_n_mag,
    input  logic                 in_n_neg,
    input  logic [DW-1:0]        in_d_mag,
    input  logic                 in_d_neg,
    input  SIDE_T                in_side,
    output logic                 out_valid,
    output logic signed [CW-1:0] out_q,
    output SIDE_T                out_side
);
    import rtct_pkg::*;

    localparam int RW = (NW > DW + CW) ? NW : DW + CW;

    logic [RW-1:0] rem_reg  [0:CW-1];
    logic [DW-1:0] dvs_reg  [0:CW-1];
    logic [CW-1:0] quo_reg  [0:CW];
    logic          neg_reg  [0:CW];
    logic          ovf_reg  [0:CW];
    logic          vld_reg  [0:CW];
    SIDE_T         side_reg [0:CW];

    logic [RW-1:0] trial [1:CW];
    logic          take  [1:CW];

    logic                 out_valid_reg;
    logic signed [CW-1:0] out_q_reg;
    logic signed [CW-1:0] q_next;
    SIDE_T                out_side_reg;

    always_comb begin
        for (int j = 1; j <= CW; j++) begin
            trial[j] = RW'(dvs_reg[j-1]) << (CW - j);
            take[j]  = rem_reg[j-1] >= trial[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= CW; j++) begin
                vld_reg[j] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j <= CW; j++) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0]  <= RW'(in_n_mag);
            dvs_reg[0]  <= in_d_mag;
            quo_reg[0]  <= '0;
            neg_reg[0]  <= in_n_neg ^ in_d_neg;
            // quotient would not fit in CW bits
            ovf_reg[0]  <= RW'(in_n_mag) >= (RW'(in_d_mag) << CW);
            side_reg[0] <= in_side;
            for (int j = 1; j <= CW; j++) begin
                if (j < CW) begin
                    rem_reg[j] <= take[j] ? rem_reg[j-1] - trial[j] : rem_reg[j-1];
                    dvs_reg[j] <= dvs_reg[j-1];
                end
                quo_reg[j]  <= quo_reg[j-1] | (take[j] ? (CW'(1) << (CW - j)) : '0);
                neg_reg[j]  <= neg_reg[j-1];
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb begin
        logic [CW-1:0] limit;
        logic [CW-1:0] mag;
        limit  = neg_reg[CW] ? (CW'(1) << (CW - 1)) : ((CW'(1) << (CW - 1)) - CW'(1));
        mag    = (ovf_reg[CW] || quo_reg[CW] > limit) ? limit : quo_reg[CW];
        q_next = neg_reg[CW] ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ce) begin
            out_valid_reg <= vld_reg[CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            out_q_reg    <= q_next;
            out_side_reg <= side_reg[CW];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_q     = out_q_reg;
    assign out_side  = out_side_reg;

endmodule

@@ rtl/ray_trace_crash_time.sv @@
// two-ray crash time solver: top level with stream ports and apb epsilon register
// throughput: one item per cycle while the output is not stalled; two divider pipelines of COORD_WIDTH+2 stages each
// set the depth, since the second quotient needs the first
// backpressure holds the whole pipeline; the input register still fills when empty
// reset (aresetn low, synchronous) clears all valid bits and sets epsilon to 7
module ray_trace_crash_time #(
    parameter int COORD_WIDTH = rtct_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rtct_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // own_pos_x, own_pos_y, own_vel_x, own_vel_y,
    // other_pos_x, other_pos_y, other_vel_x, other_vel_y
    input  logic [8*COORD_WIDTH-1:0]              s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // crash, own_time, other_time, zero pad
    output logic [((2*COORD_WIDTH+8)/8)*8-1:0]    m_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rtct_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [rtct_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [rtct_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready
);
    import rtct_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int OUT_W = ((2 * CW + 8) / 8) * 8;
    localparam int PW    = 2 * CW + 2;
    localparam int NW1   = PW + FB;
    localparam int DW1   = 2 * CW + 1;
    localparam int NW3   = CW + 1 + FB;
    localparam int NW2   = ((CW + 1 + FB > 2 * CW) ? CW + 1 + FB : 2 * CW) + 1;
    localparam logic [CW-1:0] MINUS_ONE = (FB >= CW - 1) ? (CW'(1) << (CW - 1))
                                                         : (~(CW'(1) << FB) + CW'(1));

    typedef struct packed {
        logic small_vx;
        logic small_vy;
        logic small_mvx;
        logic small_mvy;
        logic zero_vx;
        logic zero_vy;
        logic zero_mvx;
        logic zero_mvy;
        logic veq;
    } flags_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [CW:0] c_sel;
        logic signed [CW-1:0] mv_sel;
        logic signed [CW-1:0] dv_sel;
    } side1_t;

    typedef struct packed {
        mode_t                mode;
        logic signed [CW-1:0] t2;
        logic signed [CW-1:0] t3;
        logic                 veq;
    } side2_t;

    function automatic logic [CW-1:0] mag_cw(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // configuration register
    logic                 cfg_wr;
    logic [EPS_WIDTH-1:0] eps_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (cfg_wr && paddr[APB_ADDR_W-1:2] == REG_EPSILON) begin
            eps_reg <= pwdata[EPS_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_EPSILON) ? APB_DATA_W'(eps_reg) : '0;

    // pipeline control
    logic ce;
    logic m_tvalid_reg;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic d1_vld;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce || !v0_reg;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                v0_reg <= s_tvalid;
            end
            if (ce) begin
                v1_reg <= v0_reg;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
            end
            if (ce) begin
                v6_reg <= v5_reg;
                v7_reg <= v6_reg;
            end
            if (ce) begin
                v5_reg <= d1_vld;
            end
        end
    end

    // stage 0: input register
    logic [8*CW-1:0] in_reg;
    logic signed [CW-1:0] s0_px, s0_py, s0_vx, s0_vy, s0_ox, s0_oy, s0_mvx, s0_mvy;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_tdata;
        end
    end

    assign s0_px  = in_reg[0*CW +: CW];
    assign s0_py  = in_reg[1*CW +: CW];
    assign s0_vx  = in_reg[2*CW +: CW];
    assign s0_vy  = in_reg[3*CW +: CW];
    assign s0_ox  = in_reg[4*CW +: CW];
    assign s0_oy  = in_reg[5*CW +: CW];
    assign s0_mvx = in_reg[6*CW +: CW];
    assign s0_mvy = in_reg[7*CW +: CW];

    // stage 1: offsets and speed classification
    logic signed [CW:0]   s1_c1_reg, s1_c2_reg, s1_dvy_reg;
    logic signed [CW-1:0] s1_vx_reg, s1_vy_reg, s1_mvx_reg, s1_mvy_reg;
    flags_t               s1_flags_reg, flags_next;

    always_comb begin
        flags_next.small_vx  = mag_cw(s0_vx)  < CW'(eps_reg);
        flags_next.small_vy  = mag_cw(s0_vy)  < CW'(eps_reg);
        flags_next.small_mvx = mag_cw(s0_mvx) < CW'(eps_reg);
        flags_next.small_mvy = mag_cw(s0_mvy) < CW'(eps_reg);
        flags_next.zero_vx   = s0_vx  == '0;
        flags_next.zero_vy   = s0_vy  == '0;
        flags_next.zero_mvx  = s0_mvx == '0;
        flags_next.zero_mvy  = s0_mvy == '0;
        flags_next.veq       = s0_vy  == s0_mvy;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_c1_reg    <= (CW+1)'(s0_ox) - (CW+1)'(s0_px);
            s1_c2_reg    <= (CW+1)'(s0_oy) - (CW+1)'(s0_py);
            s1_dvy_reg   <= (CW+1)'(s0_vy) - (CW+1)'(s0_mvy);
            s1_vx_reg    <= s0_vx;
            s1_vy_reg    <= s0_vy;
            s1_mvx_reg   <= s0_mvx;
            s1_mvy_reg   <= s0_mvy;
            s1_flags_reg <= flags_next;
        end
    end

    // stage 2: cross products
    logic [CW:0]            c1_mag;
    logic signed [2*CW-1:0] s2_pa_reg, s2_pb_reg;
    logic signed [2*CW:0]   s2_pc_reg, s2_pd_reg;
    logic signed [CW:0]     s2_c1_reg, s2_c2_reg, s2_dvy_reg;
    logic signed [CW-1:0]   s2_vx_reg, s2_vy_reg, s2_mvx_reg, s2_mvy_reg;
    flags_t                 s2_flags_reg;
    logic                   s2_large_c1_reg;

    assign c1_mag = s1_c1_reg[CW] ? (CW+1)'(-s1_c1_reg) : (CW+1)'(s1_c1_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            s2_pa_reg       <= (2*CW)'(s1_vy_reg) * (2*CW)'(s1_mvx_reg);
            s2_pb_reg       <= (2*CW)'(s1_vx_reg) * (2*CW)'(s1_mvy_reg);
            s2_pc_reg       <= (2*CW+1)'(s1_c2_reg) * (2*CW+1)'(s1_vx_reg);
            s2_pd_reg       <= (2*CW+1)'(s1_vy_reg) * (2*CW+1)'(s1_c1_reg);
            s2_large_c1_reg <= c1_mag > (CW+1)'(eps_reg);
            s2_c1_reg       <= s1_c1_reg;
            s2_c2_reg       <= s1_c2_reg;
            s2_dvy_reg      <= s1_dvy_reg;
            s2_vx_reg       <= s1_vx_reg;
            s2_vy_reg       <= s1_vy_reg;
            s2_mvx_reg      <= s1_mvx_reg;
            s2_mvy_reg      <= s1_mvy_reg;
            s2_flags_reg    <= s1_flags_reg;
        end
    end

    // stage 3: determinant and first numerator
    logic signed [2*CW:0]   s3_det_reg;
    logic signed [PW-1:0]   s3_num_reg;
    logic signed [CW:0]     s3_c1_reg, s3_c2_reg, s3_dvy_reg;
    logic signed [CW-1:0]   s3_vx_reg, s3_vy_reg, s3_mvx_reg, s3_mvy_reg;
    flags_t                 s3_flags_reg;
    logic                   s3_large_c1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s3_det_reg      <= (2*CW+1)'(s2_pa_reg) - (2*CW+1)'(s2_pb_reg);
            s3_num_reg      <= PW'(s2_pc_reg) - PW'(s2_pd_reg);
            s3_c1_reg       <= s2_c1_reg;
            s3_c2_reg       <= s2_c2_reg;
            s3_dvy_reg      <= s2_dvy_reg;
            s3_vx_reg       <= s2_vx_reg;
            s3_vy_reg       <= s2_vy_reg;
            s3_mvx_reg      <= s2_mvx_reg;
            s3_mvy_reg      <= s2_mvy_reg;
            s3_flags_reg    <= s2_flags_reg;
            s3_large_c1_reg <= s2_large_c1_reg;
        end
    end

    // stage 4: case decode and divider operands
    mode_t          mode_next;
    logic [NW1-1:0] d1_n_next;
    logic           d1_nneg_next;
    logic [DW1-1:0] d1_d_next;
    logic           d1_dneg_next;
    side1_t         side1_next;

    logic [NW1-1:0] s4_d1_n_reg;
    logic           s4_d1_nneg_reg;
    logic [DW1-1:0] s4_d1_d_reg;
    logic           s4_d1_dneg_reg;
    side1_t         s4_side1_reg;
    logic [NW3-1:0] s4_d3_n_reg;
    logic           s4_d3_nneg_reg;
    logic [CW:0]    s4_d3_d_reg;
    logic           s4_d3_dneg_reg;
    logic           s4_veq_reg;

    always_comb begin
        logic [PW-1:0] num_mag;
        logic [DW1-1:0] det_mag;
        logic [CW:0]   c1m;
        logic [CW:0]   c2m;
        num_mag = s3_num_reg[PW-1] ? PW'(-s3_num_reg) : PW'(s3_num_reg);
        det_mag = s3_det_reg[2*CW] ? DW1'(-s3_det_reg) : DW1'(s3_det_reg);
        c1m     = s3_c1_reg[CW] ? (CW+1)'(-s3_c1_reg) : (CW+1)'(s3_c1_reg);
        c2m     = s3_c2_reg[CW] ? (CW+1)'(-s3_c2_reg) : (CW+1)'(s3_c2_reg);

        if (s3_flags_reg.small_vx) begin
            if (s3_flags_reg.small_vy) begin
                mode_next = MODE_REJECT;
            end else if (s3_flags_reg.small_mvx) begin
                if (s3_large_c1_reg || s3_flags_reg.small_mvy ||
                    s3_flags_reg.zero_vy || s3_flags_reg.zero_mvy) begin
                    mode_next = MODE_REJECT;
                end else begin
                    mode_next = MODE_COLLINEAR;
                end
            end else if (s3_flags_reg.zero_mvx || s3_flags_reg.zero_vy) begin
                mode_next = MODE_REJECT;
            end else begin
                mode_next = MODE_OWNX;
            end
        end else if (s3_det_reg == '0 || s3_flags_reg.zero_vx) begin
            mode_next = MODE_REJECT;
        end else begin
            mode_next = MODE_GENERAL;
        end

        side1_next.mode = mode_next;
        case (mode_next)
            MODE_GENERAL: begin
                d1_n_next         = NW1'(num_mag) << FB;
                d1_nneg_next      = s3_num_reg[PW-1];
                d1_d_next         = det_mag;
                d1_dneg_next      = s3_det_reg[2*CW];
                side1_next.c_sel  = s3_c1_reg;
                side1_next.mv_sel = s3_mvx_reg;
                side1_next.dv_sel = s3_vx_reg;
            end
            MODE_OWNX: begin
                // t2 = -c1 / other_vel_x
                d1_n_next         = NW1'(c1m) << FB;
                d1_nneg_next      = !s3_c1_reg[CW];
                d1_d_next         = DW1'(mag_cw(s3_mvx_reg));
                d1_dneg_next      = s3_mvx_reg[CW-1];
                side1_next.c_sel  = s3_c2_reg;
                side1_next.mv_sel = s3_mvy_reg;
                side1_next.dv_sel = s3_vy_reg;
            end
            default: begin
                // collinear: t2 = -c2 / other_vel_y
                d1_n_next         = NW1'(c2m) << FB;
                d1_nneg_next      = !s3_c2_reg[CW];
                d1_d_next         = DW1'(mag_cw(s3_mvy_reg));
                d1_dneg_next      = s3_mvy_reg[CW-1];
                side1_next.c_sel  = s3_c2_reg;
                side1_next.mv_sel = s3_mvy_reg;
                side1_next.dv_sel = s3_vy_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s4_d1_n_reg    <= d1_n_next;
            s4_d1_nneg_reg <= d1_nneg_next;
            s4_d1_d_reg    <= d1_d_next;
            s4_d1_dneg_reg <= d1_dneg_next;
            s4_side1_reg   <= side1_next;
            s4_d3_n_reg    <= NW3'(s3_c2_reg[CW] ? (CW+1)'(-s3_c2_reg)
                                                 : (CW+1)'(s3_c2_reg)) << FB;
            s4_d3_nneg_reg <= s3_c2_reg[CW];
            s4_d3_d_reg    <= s3_dvy_reg[CW] ? (CW+1)'(-s3_dvy_reg) : (CW+1)'(s3_dvy_reg);
            s4_d3_dneg_reg <= s3_dvy_reg[CW];
            s4_veq_reg     <= s3_flags_reg.veq;
        end
    end

    // first quotient, plus the collinear common-speed quotient beside it
    logic signed [CW-1:0] d1_q;
    side1_t               d1_side;
    logic                 d3_vld;
    logic signed [CW-1:0] d3_q;
    logic                 d3_veq;

    rtct_div #(
        .CW     (CW),
        .NW     (NW1),
        .DW     (DW1),
        .SIDE_T (side1_t)
    ) u_div1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_n_mag  (s4_d1_n_reg),
        .in_n_neg  (s4_d1_nneg_reg),
        .in_d_mag  (s4_d1_d_reg),
        .in_d_neg  (s4_d1_dneg_reg),
        .in_side   (s4_side1_reg),
        .out_valid (d1_vld),
        .out_q     (d1_q),
        .out_side  (d1_side)
    );

    rtct_div #(
        .CW     (CW),
        .NW     (NW3),
        .DW     (CW + 1),
        .SIDE_T (logic)
    ) u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v4_reg),
        .in_n_mag  (s4_d3_n_reg),
        .in_n_neg  (s4_d3_nneg_reg),
        .in_d_mag  (s4_d3_d_reg),
        .in_d_neg  (s4_d3_dneg_reg),
        .in_side   (s4_veq_reg),
        .out_valid (d3_vld),
        .out_q     (d3_q),
        .out_side  (d3_veq)
    );

    // stage 5: t2 times the other speed
    logic signed [2*CW-1:0] s5_prod_reg;
    side1_t                 s5_side1_reg;
    logic signed [CW-1:0]   s5_t2_reg, s5_t3_reg;
    logic                   s5_veq_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s5_prod_reg  <= (2*CW)'(d1_q) * (2*CW)'(d1_side.mv_sel);
            s5_side1_reg <= d1_side;
            s5_t2_reg    <= d1_q;
            s5_t3_reg    <= d3_q;
            s5_veq_reg   <= d3_veq;
        end
    end

    // stage 6: second numerator
    logic signed [NW2-1:0] s6_sum_reg;
    logic signed [CW-1:0]  s6_dv_reg;
    side2_t                s6_side2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s6_sum_reg <= (NW2'(s5_side1_reg.c_sel) <<< FB) +
                          ((s5_side1_reg.mode == MODE_COLLINEAR) ? NW2'(0)
                                                                 : NW2'(s5_prod_reg));
            s6_dv_reg         <= s5_side1_reg.dv_sel;
            s6_side2_reg.mode <= s5_side1_reg.mode;
            s6_side2_reg.t2   <= s5_t2_reg;
            s6_side2_reg.t3   <= s5_t3_reg;
            s6_side2_reg.veq  <= s5_veq_reg;
        end
    end

    // stage 7: sign-magnitude operands for the second divider
    logic [NW2-1:0] s7_n_reg;
    logic           s7_nneg_reg;
    logic [CW-1:0]  s7_d_reg;
    logic           s7_dneg_reg;
    side2_t         s7_side2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            s7_n_reg     <= s6_sum_reg[NW2-1] ? NW2'(-s6_sum_reg) : NW2'(s6_sum_reg);
            s7_nneg_reg  <= s6_sum_reg[NW2-1];
            s7_d_reg     <= mag_cw(s6_dv_reg);
            s7_dneg_reg  <= s6_dv_reg[CW-1];
            s7_side2_reg <= s6_side2_reg;
        end
    end

    // second quotient: own time
    logic                 d2_vld;
    logic signed [CW-1:0] d2_q;
    side2_t               d2_side;

    rtct_div #(
        .CW     (CW),
        .NW     (NW2),
        .DW     (CW),
        .SIDE_T (side2_t)
    ) u_div2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (v7_reg),
        .in_n_mag  (s7_n_reg),
        .in_n_neg  (s7_nneg_reg),
        .in_d_mag  (s7_d_reg),
        .in_d_neg  (s7_dneg_reg),
        .in_side   (s7_side2_reg),
        .out_valid (d2_vld),
        .out_q     (d2_q),
        .out_side  (d2_side)
    );

    // final checks into the output register
    logic [OUT_W-1:0] m_tdata_reg, m_tdata_next;

    always_comb begin
        logic signed [CW-1:0] t1;
        logic signed [CW-1:0] t2;
        logic                 ok;
        logic                 crash;
        t1 = d2_q;
        t2 = d2_side.t2;
        ok = d2_side.mode != MODE_REJECT;
        if (d2_side.mode == MODE_COLLINEAR) begin
            if (t1 != '0 && t2 != '0 && t1[CW-1] != t2[CW-1]) begin
                // opposite directions: the one behind starts at zero
                if (t1[CW-1]) begin
                    t1 = '0;
                end else begin
                    t2 = '0;
                end
            end else if (t1 > 0 && t2 > 0) begin
                if (d2_side.veq) begin
                    ok = 1'b0;
                end else begin
                    t1 = d2_side.t3;
                    t2 = d2_side.t3;
                end
            end
        end
        crash = ok && (t1 >= t2) && !t1[CW-1] && !t2[CW-1];
        m_tdata_next = OUT_W'({(ok ? t2 : CW'(0)), (crash ? t1 : $signed(MINUS_ONE)), crash});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= d2_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tdata = m_tdata_reg;

    // checks
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    a_div_lockstep: assert property (@(posedge aclk) disable iff (!aresetn)
        d1_vld == d3_vld)
        else $error("parallel divider pipelines out of step");

    a_crash_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> !m_tdata[CW])
        else $error("crash reported with negative own time");

    a_miss_minus_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[CW:1] == MINUS_ONE)
        else $error("miss without own time of minus one");

    a_input_captured: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v0_reg)
        else $error("input transfer not captured");

endmodule

@@ test/tb.sv @@
// testbench for the two-ray crash time solver: predictor, scoreboard and stream stimulus
module tb;
    import rtct_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int OUT_W = ((2*CW+8)/8)*8;
    localparam int LATENCY = 2*CW + 12;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic             crash;
        logic [CW-1:0]    own_time;
        logic [CW-1:0]    other_time;
    } crash_result_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [8*CW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic psel, penable, pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    ray_trace_crash_time u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    crash_result_t expected_q[$];
    logic [15:0] eps_model;
    int errors;
    int idle_cycles;
    bit stall_enable;
    bit gaps_enable;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // helpers on 160-bit signed values keep products exact
    typedef logic signed [159:0] wide_t;

    function automatic wide_t sat_time(wide_t v);
        wide_t hi_lim;
        wide_t lo_lim;
        hi_lim = wide_t'(32'sh7fffffff);
        lo_lim = -wide_t'(64'sh80000000);
        if (v > hi_lim) return hi_lim;
        if (v < lo_lim) return lo_lim;
        return v;
    endfunction

    // truncating quotient; sv signed division rounds toward zero
    function automatic wide_t fix_div(wide_t n, wide_t d);
        return sat_time(n / d);
    endfunction

    function automatic wide_t abs_w(wide_t v);
        return v < 0 ? -v : v;
    endfunction

    function automatic crash_result_t solve_crash(logic [8*CW-1:0] d);
        wide_t px, py, vx, vy, ox, oy, mvx, mvy, c1, c2, t1, t2, det, den, eps;
        bit ok;
        bit crash;
        crash_result_t r;
        px  = wide_t'($signed(d[0*CW +: CW]));
        py  = wide_t'($signed(d[1*CW +: CW]));
        vx  = wide_t'($signed(d[2*CW +: CW]));
        vy  = wide_t'($signed(d[3*CW +: CW]));
        ox  = wide_t'($signed(d[4*CW +: CW]));
        oy  = wide_t'($signed(d[5*CW +: CW]));
        mvx = wide_t'($signed(d[6*CW +: CW]));
        mvy = wide_t'($signed(d[7*CW +: CW]));
        eps = wide_t'({1'b0, eps_model});
        c1 = ox - px;
        c2 = oy - py;
        t1 = 0;
        t2 = 0;
        ok = 1'b1;
        if (abs_w(vx) < eps) begin
            if (abs_w(vy) < eps) begin
                ok = 1'b0;
            end else if (abs_w(mvx) < eps) begin
                if (abs_w(c1) > eps || abs_w(mvy) < eps || vy == 0 || mvy == 0) begin
                    ok = 1'b0;
                end else begin
                    t1 = fix_div(c2 <<< FB, vy);
                    t2 = fix_div((-c2) <<< FB, mvy);
                    if (t1 != 0 && t2 != 0 && ((t1 < 0) != (t2 < 0))) begin
                        if (t1 < 0) t1 = 0;
                        else t2 = 0;
                    end else if (t1 > 0 && t2 > 0) begin
                        den = vy - mvy;
                        if (den == 0) ok = 1'b0;
                        else begin
                            t1 = fix_div(c2 <<< FB, den);
                            t2 = t1;
                        end
                    end
                end
            end else if (mvx == 0 || vy == 0) begin
                ok = 1'b0;
            end else begin
                t2 = fix_div((-c1) <<< FB, mvx);
                t1 = fix_div((c2 <<< FB) + t2 * mvy, vy);
            end
        end else begin
            det = vy * mvx - vx * mvy;
            if (det == 0 || vx == 0) begin
                ok = 1'b0;
            end else begin
                t2 = fix_div((c2 * vx - vy * c1) <<< FB, det);
                t1 = fix_div((c1 <<< FB) + mvx * t2, vx);
            end
        end
        crash = ok && (t1 >= t2) && (t1 >= 0) && (t2 >= 0);
        r.crash = crash;
        r.own_time = crash ? t1[CW-1:0] : -(CW'(1) << FB);
        r.other_time = ok ? t2[CW-1:0] : '0;
        return r;
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        eps_model = value[15:0];
    endtask

    task automatic send_pair(input logic [8*CW-1:0] item);
        int gap;
        if (gaps_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(solve_crash(item));
    endtask

    task automatic drain_results();
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 15) - 8;
            1: return $urandom;
            2: return {{(CW-20){$urandom_range(0, 1) == 1}}, 20'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return {{(CW-24){$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    function automatic logic [8*CW-1:0] make_pair(
        logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] vx, logic [CW-1:0] vy,
        logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] mvx, logic [CW-1:0] mvy);
        return {mvy, mvx, oy, ox, vy, vx, py, px};
    endfunction

    task automatic test_directed();
        logic [CW-1:0] one;
        one = CW'(1) << FB;
        // crossing paths in the general solve
        send_pair(make_pair(0, 0, one, one, 10*one, 0, 0, one));
        // both own speeds small
        send_pair(make_pair(0, 0, 1, 2, one, one, one, one));
        // own x small, other x not small
        send_pair(make_pair(0, 0, 0, one, 4*one, 4*one, -one, 0));
        // collinear, approaching
        send_pair(make_pair(0, 0, 0, one, 0, 8*one, 0, -one));
        // collinear, same direction, times of opposite sign
        send_pair(make_pair(0, 0, 0, 2*one, 0, 8*one, 0, one));
        // collinear rejected for large x offset
        send_pair(make_pair(0, 0, 0, one, 100, 8*one, 0, -one));
        // collinear with speeds of equal size and positive times
        send_pair(make_pair(0, 0, 0, one, 0, 8*one, 0, -one));
        // parallel rays, zero determinant
        send_pair(make_pair(0, 0, one, one, one, 0, 2*one, 2*one));
        // field extremes
        send_pair(make_pair(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff));
        send_pair(make_pair('1, '1, '1, '1, '1, '1, '1, '1));
        send_pair(make_pair('0, '0, '0, '0, '0, '0, '0, '0));
        send_pair(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                            32'h80000000, 32'h80000000, 1, 32'h80000000));
        // crossing paths where other arrives first
        send_pair(make_pair(0, 0, one, 0, 5*one, -5*one, 0, 2*one));
        s_tvalid <= 1'b0;
        drain_results();
    endtask

    task automatic test_random(input int count);
        logic [CW-1:0] f[8];
        for (int n = 0; n < count; n++) begin
            foreach (f[i]) f[i] = rand_coord();
            // bias toward the small-speed branches
            if ($urandom_range(0, 4) == 0) f[2] = $urandom_range(0, 15) - 8;
            if ($urandom_range(0, 6) == 0) begin
                f[6] = $urandom_range(0, 15) - 8;
                f[4] = f[0] + ($urandom_range(0, 15) - 8);
            end
            send_pair(make_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]));
        end
        s_tvalid <= 1'b0;
        drain_results();
    endtask

    // stall bursts on the result side
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (stall_enable && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        crash_result_t got;
        crash_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.crash      = m_tdata[0];
            got.own_time   = m_tdata[1 +: CW];
            got.other_time = m_tdata[1+CW +: CW];
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.crash !== want.crash) begin
                    $error("crash: expected %0d got %0d", want.crash, got.crash);
                    errors++;
                end
                if (got.own_time !== want.own_time) begin
                    $error("own_time: expected %h got %h", want.own_time, got.own_time);
                    errors++;
                end
                if (got.other_time !== want.other_time) begin
                    $error("other_time: expected %h got %h", want.other_time, got.other_time);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        eps_model = EPS_RESET;
        stall_enable = 1'b1;
        gaps_enable = 1'b1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        apb_write({REG_EPSILON, 2'b00}, 32'd0);
        test_directed();
        test_random(300);
        apb_write({REG_EPSILON, 2'b00}, 32'd65535);
        test_directed();
        test_random(300);
        apb_write({REG_EPSILON, 2'b00}, 32'd1);
        test_random(300);
        apb_write({REG_EPSILON, 2'b00}, 32'($urandom_range(2, 4096)));
        test_random(400);
        apb_write({REG_EPSILON, 2'b00}, 32'd7);
        test_random(300);
        // closing stretch at full rate
        stall_enable = 1'b0;
        gaps_enable = 1'b0;
        test_random(200);

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
